// ===== hdl/sdti_pkg.sv =====
// ---------------------------------------------------------------------------
// sdti_pkg: shared types and constants
// Word and remainder types, reciprocal constants for the divide-by-ten step,
// and the default scale limit.
// ---------------------------------------------------------------------------
package sdti_pkg;

  localparam int WORD_W = 32;
  localparam int SCALE_W = 5;
  localparam int REM_W = 4;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [REM_W-1:0]  rem_t;

  // Largest scale accepted before saturation.
  localparam int MAX_SCALE_DEFAULT = 28;

  // ceil(2^35 / 10): exact reciprocal for any 32-bit dividend.
  localparam logic [WORD_W-1:0] RECIP_10 = 32'hCCCC_CCCD;
  localparam int RECIP_10_SHIFT = 35;

  // floor(2^32 / 10); 2^32 leaves a remainder of six.
  localparam logic [28:0] TWO32_DIV10 = 29'd429496729;
  localparam logic [2:0]  TWO32_MOD10 = 3'd6;

  // Small reciprocal for values below 64: ceil(2^11 / 10).
  localparam logic [7:0] RECIP_10_SMALL = 8'd205;

endpackage

// ===== hdl/sdti_div10_step.sv =====
// ---------------------------------------------------------------------------
// sdti_div10_step: one word of a long division by ten
// Divides (rem_in * 2^32 + word_in) by ten and returns the 32-bit quotient
// word and the new remainder. Shared by every word and every digit.
// ---------------------------------------------------------------------------
module sdti_div10_step
  import sdti_pkg::*;
(
  input  word_t word_in,
  input  rem_t  rem_in,
  output word_t quot,
  output rem_t  rem_out
);

  logic [63:0] prod;
  logic [28:0] word_q;
  logic [31:0] word_q10;
  rem_t        word_r;
  logic [5:0]  carry_t;
  logic [13:0] small_prod;
  logic [2:0]  carry_q;
  logic [5:0]  carry_q10;
  logic [32:0] rem_part;
  logic [32:0] quot_sum;

  // Quotient and remainder of the word alone, by reciprocal multiply.
  assign prod     = {32'd0, word_in} * {32'd0, RECIP_10};
  assign word_q   = prod[63:RECIP_10_SHIFT];
  assign word_q10 = ({3'd0, word_q} << 3) + ({3'd0, word_q} << 1);
  assign word_r   = rem_t'(word_in - word_q10);

  // The incoming remainder contributes rem*6 that can carry into the quotient.
  assign carry_t    = 6'({2'd0, rem_in} * {3'd0, TWO32_MOD10}) + {2'd0, word_r};
  assign small_prod = {8'd0, carry_t} * {6'd0, RECIP_10_SMALL};
  assign carry_q    = small_prod[13:11];
  assign carry_q10  = ({3'd0, carry_q} << 3) + ({3'd0, carry_q} << 1);
  assign rem_out    = rem_t'(carry_t - carry_q10);

  // Full quotient word: rem * floor(2^32/10) + word quotient + carry.
  assign rem_part = {29'd0, rem_in} * {4'd0, TWO32_DIV10};
  assign quot_sum = rem_part + {4'd0, word_q} + {30'd0, carry_q};
  assign quot     = quot_sum[31:0];

endmodule

// ===== hdl/scaled_decimal_to_int32.sv =====
// ---------------------------------------------------------------------------
// scaled_decimal_to_int32: scaled decimal to signed 32-bit integer
// Truncates a 96-bit magnitude by ten to the power of the scale and
// range-checks and signs the result.
// ---------------------------------------------------------------------------
// A request carries a 96-bit magnitude in three words, a scale and a sign.
// The magnitude is divided by ten once per unit of scale (scales above
// MAX_SCALE saturate) through one shared word divider, one 32-bit word per
// cycle. The finishing state waits while an earlier result is still stalled,
// and a new request is taken once the sequencer is back in idle after its
// result is registered.
// Results of 2^31 or more in magnitude, including -2^31, give overflow with
// value zero. The result register lets the next request start while the
// previous result is still stalled.
module scaled_decimal_to_int32
  import sdti_pkg::*;
#(
  parameter int MAX_SCALE = MAX_SCALE_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  logic [31:0]        low_word,
  input  logic [31:0]        mid_word,
  input  logic [31:0]        high_word,
  input  logic [4:0]         scale,
  input  logic               negative,
  output logic               res_valid,
  input  logic               res_stall,
  output logic signed [31:0] value,
  output logic               overflow
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_DIV   = 2'd1;
  localparam logic [1:0] ST_FINAL = 2'd2;

  localparam logic [SCALE_W-1:0] SCALE_LIMIT = SCALE_W'(MAX_SCALE);

  logic [1:0]         state;
  word_t              mag [3];
  rem_t               rem;
  logic [1:0]         widx;
  logic [SCALE_W-1:0] count;
  logic               neg;

  logic               req_take;
  logic               res_free;
  logic [SCALE_W-1:0] scale_sat;
  word_t              step_quot;
  rem_t               step_rem;
  logic               mag_ovf;
  word_t              mag_signed;

  assign req_stall = (state != ST_IDLE);
  assign req_take  = req_valid && !req_stall;
  assign res_free  = !res_valid || !res_stall;
  assign scale_sat = (scale > SCALE_LIMIT) ? SCALE_LIMIT : scale;

  // Shared divider works on the word selected by the sequencer.
  sdti_div10_step u_step (
    .word_in (mag[widx]),
    .rem_in  (rem),
    .quot    (step_quot),
    .rem_out (step_rem)
  );

  // Sequencer: load, divide word by word from the top, then finish.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (req_take) begin
            state <= (scale_sat == '0) ? ST_FINAL : ST_DIV;
          end
        end
        ST_DIV: begin
          if (widx == 2'd0 && count == SCALE_W'(1)) begin
            state <= ST_FINAL;
          end
        end
        ST_FINAL: begin
          if (res_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Datapath registers for the magnitude and the division progress.
  always_ff @(posedge clk) begin
    if (req_take) begin
      mag[0] <= low_word;
      mag[1] <= mid_word;
      mag[2] <= high_word;
      neg    <= negative;
      count  <= scale_sat;
      rem    <= '0;
      widx   <= 2'd2;
    end else if (state == ST_DIV) begin
      mag[widx] <= step_quot;
      if (widx == 2'd0) begin
        rem   <= '0;
        widx  <= 2'd2;
        count <= count - SCALE_W'(1);
      end else begin
        rem  <= step_rem;
        widx <= widx - 2'd1;
      end
    end
  end

  // Range check and sign of the truncated magnitude.
  assign mag_ovf    = (mag[2] != '0) || (mag[1] != '0) || mag[0][31];
  assign mag_signed = neg ? (~mag[0] + 32'd1) : mag[0];

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == ST_FINAL && res_free) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINAL && res_free) begin
      overflow <= mag_ovf;
      value    <= mag_ovf ? 32'sd0 : $signed(mag_signed);
    end
  end

  // The running remainder is always a decimal digit during division.
  a_rem_digit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (rem < rem_t'(10)))
    else $error("division remainder out of range");

  // A new result is only produced from the finishing state.
  a_res_from_final: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> ($past(state) == ST_FINAL))
    else $error("result appeared outside the finishing state");

  // An overflowing result always carries a zero value.
  a_ovf_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && overflow) |-> (value == 32'sd0))
    else $error("overflow with nonzero value");

  // A request with a nonzero scale enters the division loop.
  a_take_div: assert property (@(posedge clk) disable iff (rst)
    (req_take && scale != '0) |=> (state == ST_DIV))
    else $error("division not started after request");

endmodule
